// File: sv/dbcf_pkg.sv
// ----------------------------------------------------------------------------
// dbcf_pkg
// Shared types and constants for the deadband change filter.
// ----------------------------------------------------------------------------
package dbcf_pkg;

    localparam int SAMPLE_W = 32;
    localparam int BAND_W   = 32;
    localparam int DIFF_W   = SAMPLE_W + 1;
    localparam int PROD_W   = 64;

    // Register indexes on the configuration port
    localparam logic CFG_IDX_MODE = 1'b0;
    localparam logic CFG_IDX_BAND = 1'b1;

    // Relative scale 25600 = 2^14 + 2^13 + 2^10 (100 percent times 256)
    localparam int REL_SH0 = 14;
    localparam int REL_SH1 = 13;
    localparam int REL_SH2 = 10;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [SAMPLE_W-1:0]        mag_t;
    typedef logic [BAND_W-1:0]          band_t;

    // Filter state carried from one item to the next
    typedef struct packed {
        logic    first_pending;
        sample_t last_reported;
        mag_t    last_mag;
    } dbcf_state_t;

    // Configuration seen by the evaluation logic
    typedef struct packed {
        logic  relative_mode;
        band_t band_threshold;
    } dbcf_cfg_t;

endpackage

// File: sv/dbcf_eval.sv
// ----------------------------------------------------------------------------
// dbcf_eval
// Deadband decision for one sample: report bit and the next filter state.
// ----------------------------------------------------------------------------
module dbcf_eval
    import dbcf_pkg::*;
(
    input  sample_t     sample,
    input  dbcf_state_t state,
    input  dbcf_cfg_t   cfg,
    output logic        report,
    output dbcf_state_t state_next
);

    logic signed [DIFF_W-1:0] diff_s;
    logic [DIFF_W-1:0]        diff;
    logic [47:0]              diff_ext;
    logic [47:0]              scaled;
    logic [PROD_W-1:0]        band_prod;
    mag_t                     sample_mag;
    logic                     pass_abs;
    logic                     pass_rel;

    // Distance from the last reported value, exact in 33 bits
    assign diff_s = {sample[SAMPLE_W-1], sample} - {state.last_reported[SAMPLE_W-1],
                                                    state.last_reported};
    assign diff   = diff_s[DIFF_W-1] ? DIFF_W'(-diff_s) : DIFF_W'(diff_s);

    // Scale the distance by 25600 with shifts and adds
    assign diff_ext = 48'(diff);
    assign scaled   = (diff_ext << REL_SH0) + (diff_ext << REL_SH1) + (diff_ext << REL_SH2);

    // Threshold times last reported magnitude
    assign band_prod = PROD_W'(cfg.band_threshold) * PROD_W'(state.last_mag);

    // Compare in each mode
    assign pass_abs = diff >= DIFF_W'(cfg.band_threshold);
    assign pass_rel = (state.last_mag == '0) || (PROD_W'(scaled) >= band_prod);

    assign report = state.first_pending || (cfg.relative_mode ? pass_rel : pass_abs);

    // Magnitude of the sample, kept for the next relative compare
    assign sample_mag = sample[SAMPLE_W-1] ? mag_t'(-sample) : mag_t'(sample);

    // Advance the state: first flag drops, a reported sample becomes the reference
    always_comb
    begin
        state_next               = state;
        state_next.first_pending = 1'b0;
        if (report)
        begin
            state_next.last_reported = sample;
            state_next.last_mag      = sample_mag;
        end
    end

endmodule

// File: sv/deadband_change_filter_core.sv
// ----------------------------------------------------------------------------
// deadband_change_filter_core
// Deadband change filter over a stream of signed 32-bit samples.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries sample and update_request.
//   Output channel (out_valid/out_ready) carries one result item per input
//   item: handled, changed and value_out. Items without update_request give
//   handled = 0, changed = 0, value_out = 0 and leave the state alone.
//   Configuration: cfg_we writes cfg_data to register cfg_index
//   (0 relative_mode, 1 band_threshold); write only while the block is idle.
//   Path: an accepted item passes the input register, then the result
//   register, which raises out_valid; a receiver stall can hold it back.
//   Throughput: one item per cycle when the receiver does not stall; the
//   decision for one item (subtract, constant scale, one 32x32 multiply,
//   compare) sits between the input register and the result register, and
//   the state register is updated at the same edge so the next item sees it.
//   Reset: no items held, first sample pending, last reported value zero,
//   registers zero (absolute mode, zero deadband).
//   Receiver stall: the result register holds; one more item is taken into
//   the input register, then in_ready drops until out_ready returns.
// ----------------------------------------------------------------------------
module deadband_change_filter_core
    import dbcf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,

    input  logic    in_valid,
    output logic    in_ready,
    input  sample_t sample,
    input  logic    update_request,

    output logic    out_valid,
    input  logic    out_ready,
    output logic    handled,
    output logic    changed,
    output sample_t value_out,

    input  logic    cfg_we,
    input  logic    cfg_index,
    input  band_t   cfg_data
);

    logic        s1_valid_reg;
    sample_t     s1_sample_reg;
    logic        s1_req_reg;

    logic        out_valid_reg;
    logic        handled_reg;
    logic        changed_reg;
    sample_t     value_reg;

    dbcf_cfg_t   cfg_reg;
    dbcf_state_t state_reg;
    dbcf_state_t state_next;
    logic        report;
    logic        advance;

    // Result register is free or being drained
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || advance;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_IDX_MODE: cfg_reg.relative_mode  <= cfg_data[0];
                CFG_IDX_BAND: cfg_reg.band_threshold <= cfg_data;
                default:      cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Input register: take an item whenever the stage is free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_sample_reg <= sample;
            s1_req_reg    <= update_request;
        end
    end

    // Deadband decision
    dbcf_eval u_eval (
        .sample     (s1_sample_reg),
        .state      (state_reg),
        .cfg        (cfg_reg),
        .report     (report),
        .state_next (state_next)
    );

    // Filter state: update only on a handled item moving to the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.first_pending <= 1'b1;
            state_reg.last_reported <= '0;
            state_reg.last_mag      <= '0;
        end
        else if (advance && s1_valid_reg && s1_req_reg)
        begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            handled_reg <= s1_req_reg;
            changed_reg <= s1_req_reg && report;
            value_reg   <= s1_req_reg ? s1_sample_reg : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign handled   = handled_reg;
    assign changed   = changed_reg;
    assign value_out = value_reg;

endmodule

// File: sv/dbcf_checker.sv
// ----------------------------------------------------------------------------
// dbcf_checker
// Port-level checks for the deadband change filter, bound to the top level.
// ----------------------------------------------------------------------------
module dbcf_checker
    import dbcf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_ready,
    input  logic    out_valid,
    input  logic    out_ready,
    input  logic    handled,
    input  logic    changed,
    input  sample_t value_out
);

    // Hold a stalled result item
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(handled)
                                       && $stable(changed) && $stable(value_out)))
        else $error("stalled result item changed");

    // Drop nothing into an unhandled item
    a_unhandled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !handled) |-> (!changed && value_out == '0))
        else $error("unhandled item carries data");

    // Clear the output during reset
    a_reset: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result valid during reset");

    // Accept when the result side is empty
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty result register");

endmodule

bind deadband_change_filter_core dbcf_checker u_dbcf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .handled   (handled),
    .changed   (changed),
    .value_out (value_out)
);

// File: tb/deadband_change_filter_core_tb.sv
// ----------------------------------------------------------------------------
// deadband_change_filter_core_tb
// Self-checking bench for the deadband change filter. A directed plan covers
// the first sample, no-request items, zero and full-scale deadbands and both
// modes. Random phases follow, each with its own mode and deadband, and with
// samples aimed at the deadband edge. Results are checked in order against a
// behavioral predictor or, where a plan row gives them, its expected values.
// ----------------------------------------------------------------------------
module deadband_change_filter_core_tb;
    import dbcf_pkg::*;

    localparam longint REL_SCALE     = 25600;
    localparam int     CYCLE_LIMIT   = 200000;
    localparam int     PHASE_COUNT   = 11;
    localparam int     PHASE_ITEMS   = 100;
    localparam int     PLAN_LEN      = 29;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct packed {
        logic    handled;
        logic    changed;
        sample_t value;
    } filter_result_t;

    // One step of the directed plan: a register write or an item
    typedef struct packed {
        row_kind_t kind;
        logic      reg_idx;
        band_t     reg_val;
        sample_t   din;
        logic      req;
        logic      known;
        logic      exp_handled;
        logic      exp_changed;
        sample_t   exp_value;
    } plan_row_t;

    logic    clk = 1'b0;
    logic    rst_n;
    logic    in_valid;
    logic    in_ready;
    sample_t sample;
    logic    update_request;
    logic    out_valid;
    logic    out_ready;
    logic    handled;
    logic    changed;
    sample_t value_out;
    logic    cfg_we;
    logic    cfg_index;
    band_t   cfg_data;

    // Predictor state and register copies
    logic    track_first = 1'b1;
    sample_t track_last  = '0;
    logic    mode_reg    = 1'b0;
    band_t   band_reg    = '0;

    filter_result_t expected_results[$];
    int             mismatch_count = 0;
    int             cycle_count    = 0;
    bit             steady         = 1'b0;

    plan_row_t plan [PLAN_LEN] = '{
        // no request before the first sample
        '{ROW_ITEM, CFG_IDX_MODE, '0, 32'sh7FFF_FFFF, 1'b0, 1'b1, 1'b0, 1'b0, '0},
        // first sample is always reported
        '{ROW_ITEM, CFG_IDX_MODE, '0, 32'sh8000_0000, 1'b1, 1'b1, 1'b1, 1'b1, 32'sh8000_0000},
        // zero deadband reports everything
        '{ROW_ITEM, CFG_IDX_MODE, '0, 32'sh7FFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1, 32'sh7FFF_FFFF},
        '{ROW_ITEM, CFG_IDX_MODE, '0, 32'sh0000_007B, 1'b0, 1'b1, 1'b0, 1'b0, '0},
        '{ROW_CFG,  CFG_IDX_BAND, 32'hFFFF_FFFF, '0, 1'b0, 1'b0, 1'b0, 1'b0, '0},
        // full-scale swing exactly meets the largest deadband
        '{ROW_ITEM, CFG_IDX_MODE, '0, 32'sh8000_0000, 1'b1, 1'b1, 1'b1, 1'b1, 32'sh8000_0000},
        '{ROW_ITEM, CFG_IDX_MODE, '0, 32'sh0000_0000, 1'b1, 1'b1, 1'b1, 1'b0, 32'sh0000_0000},
        '{ROW_CFG,  CFG_IDX_BAND, 32'd100, '0, 1'b0, 1'b0, 1'b0, 1'b0, '0},
        // distance of exactly the deadband is reported
        '{ROW_ITEM, CFG_IDX_MODE, '0, 32'sh8000_0064, 1'b1, 1'b1, 1'b1, 1'b1, 32'sh8000_0064},
        '{ROW_ITEM, CFG_IDX_MODE, '0, 32'sh8000_00C7, 1'b1, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_ITEM, CFG_IDX_MODE, '0, 32'sh8000_0000, 1'b1, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_CFG,  CFG_IDX_MODE, 32'd1, '0, 1'b0, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_CFG,  CFG_IDX_BAND, 32'd0, '0, 1'b0, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_ITEM, CFG_IDX_MODE, '0, 32'sh0000_0005, 1'b1, 1'b0, 1'b0, 1'b0, '0},
        // one hundred percent in relative mode
        '{ROW_CFG,  CFG_IDX_BAND, 32'd25600, '0, 1'b0, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_ITEM, CFG_IDX_MODE, '0, 32'sh0000_000A, 1'b1, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_ITEM, CFG_IDX_MODE, '0, 32'sh0000_0013, 1'b1, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_ITEM, CFG_IDX_MODE, '0, 32'sh0000_0000, 1'b1, 1'b0, 1'b0, 1'b0, '0},
        // last reported zero in relative mode
        '{ROW_ITEM, CFG_IDX_MODE, '0, 32'sh0000_03E8, 1'b1, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_ITEM, CFG_IDX_MODE, '0, 32'sh0000_004D, 1'b0, 1'b1, 1'b0, 1'b0, '0},
        '{ROW_ITEM, CFG_IDX_MODE, '0, 32'sh8000_0000, 1'b1, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_CFG,  CFG_IDX_BAND, 32'hFFFF_FFFF, '0, 1'b0, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_ITEM, CFG_IDX_MODE, '0, 32'sh7FFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_ITEM, CFG_IDX_MODE, '0, 32'sh0000_0000, 1'b1, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_ITEM, CFG_IDX_MODE, '0, 32'shFFFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_CFG,  CFG_IDX_MODE, 32'd0, '0, 1'b0, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_CFG,  CFG_IDX_BAND, 32'd0, '0, 1'b0, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_ITEM, CFG_IDX_MODE, '0, 32'shFFFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_ITEM, CFG_IDX_MODE, '0, 32'shFFFF_FFFE, 1'b0, 1'b0, 1'b0, 1'b0, '0}
    };

    deadband_change_filter_core uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .sample         (sample),
        .update_request (update_request),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .handled        (handled),
        .changed        (changed),
        .value_out      (value_out),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("deadband_change_filter_core verification failed");
            $finish;
        end
    end

    function automatic mag_t magnitude_of(sample_t v);
        return v[SAMPLE_W-1] ? mag_t'(-v) : mag_t'(v);
    endfunction

    // Decide handled/changed for one item and advance the filter state
    function automatic filter_result_t predict_filter(sample_t s, logic req);
        filter_result_t           r;
        logic signed [DIFF_W-1:0] delta;
        logic [DIFF_W-1:0]        span;
        mag_t                     last_mag;
        logic                     report;
        r = '0;
        if (req)
        begin
            report = 1'b1;
            if (track_first)
                track_first = 1'b0;
            else
            begin
                delta    = {s[SAMPLE_W-1], s} - {track_last[SAMPLE_W-1], track_last};
                span     = delta[DIFF_W-1] ? -delta : delta;
                last_mag = magnitude_of(track_last);
                if (!mode_reg)
                    report = (span >= DIFF_W'(band_reg));
                else if (last_mag != '0)
                    report = (PROD_W'(span) * PROD_W'(REL_SCALE))
                             >= (PROD_W'(band_reg) * PROD_W'(last_mag));
            end
            if (report)
                track_last = s;
            r.handled = 1'b1;
            r.changed = report;
            r.value   = s;
        end
        return r;
    endfunction

    function automatic band_t pick_band();
        case ($urandom_range(0, 6))
            0:       return '0;
            1:       return '1;
            2:       return band_t'($urandom_range(0, 255));
            3:       return band_t'($urandom_range(0, 1 << 20));
            4:       return band_t'($urandom);
            5:       return band_t'($urandom_range(0, 25600 * 3));
            default: return band_t'($urandom_range(1, 16));
        endcase
    endfunction

    // Mix of full-range values, extremes, samples near the last reported value and near the deadband edge
    function automatic sample_t pick_sample();
        longint  reach;
        sample_t s;
        case ($urandom_range(0, 5))
            0, 1: s = sample_t'($urandom);
            2:
            begin
                case ($urandom_range(0, 4))
                    0:       s = 32'sh8000_0000;
                    1:       s = 32'sh7FFF_FFFF;
                    2:       s = '0;
                    3:       s = -32'sd1;
                    default: s = 32'sd1;
                endcase
            end
            3: s = track_last + sample_t'($urandom_range(0, 600)) - 32'sd300;
            default:
            begin
                reach = mode_reg
                      ? (longint'(band_reg) * longint'(magnitude_of(track_last))) / REL_SCALE
                      : longint'(band_reg);
                reach = reach + longint'($urandom_range(0, 4)) - 2;
                s = $urandom_range(0, 1) ? track_last + sample_t'(reach)
                                         : track_last - sample_t'(reach);
            end
        endcase
        return s;
    endfunction

    // Write one register and mirror it in the predictor
    task automatic write_reg(logic idx, band_t val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        if (idx == CFG_IDX_MODE)
            mode_reg = val[0];
        else
            band_reg = val;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one item after a random gap, none in steady phases; log its expectation on acceptance
    task automatic send_item(sample_t s, logic req, logic known, filter_result_t typed);
        int unsigned    gap;
        filter_result_t want;
        gap = steady ? 0 : $urandom_range(0, 11);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        sample         <= s;
        update_request <= req;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        want = predict_filter(s, req);
        if (known)
            want = typed;
        expected_results.push_back(want);
    endtask

    // Hold off the sender until every result is back
    task automatic settle();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Drain result items with random stalls outside steady phases and check each one
    initial
    begin : result_check
        int unsigned    stall;
        filter_result_t want;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 11);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            if (expected_results.size() == 0)
            begin
                $error("result item with nothing expected: value_out %0d", value_out);
                mismatch_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (handled !== want.handled)
                begin
                    $error("handled: expected %0b, got %0b", want.handled, handled);
                    mismatch_count++;
                end
                if (changed !== want.changed)
                begin
                    $error("changed: expected %0b, got %0b", want.changed, changed);
                    mismatch_count++;
                end
                if (value_out !== want.value)
                begin
                    $error("value_out: expected %0d, got %0d", want.value, value_out);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin : stimulus
        filter_result_t typed;
        in_valid       <= 1'b0;
        sample         <= '0;
        update_request <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_index      <= CFG_IDX_MODE;
        cfg_data       <= '0;
        rst_n          <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Walk the directed plan
        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
            begin
                settle();
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end
            else
            begin
                typed = '{plan[i].exp_handled, plan[i].exp_changed, plan[i].exp_value};
                send_item(plan[i].din, plan[i].req, plan[i].known, typed);
            end
        end
        settle();

        // Random phases, each with fresh settings; some run without idling
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            steady = (phase % 4 == 1);
            write_reg(CFG_IDX_MODE, band_t'($urandom_range(0, 1)));
            write_reg(CFG_IDX_BAND, pick_band());
            repeat (PHASE_ITEMS)
                send_item(pick_sample(), ($urandom_range(0, 7) != 0), 1'b0, '0);
            settle();
        end

        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("deadband_change_filter_core verification clean");
        else
            $display("deadband_change_filter_core verification failed");
        $finish;
    end

endmodule

// File: filelist.f
sv/dbcf_pkg.sv
sv/dbcf_eval.sv
sv/deadband_change_filter_core.sv
sv/dbcf_checker.sv
tb/deadband_change_filter_core_tb.sv
